/* design/jsesc_pkg.sv */
// ----------------------------------------------------------------------------
// jsesc_pkg
// Types, character codes and helper functions shared by the JSON string
// escaper with UTF-8 validation.
// ----------------------------------------------------------------------------
package jsesc_pkg;

  localparam logic KIND_BYTE = 1'b0;
  localparam logic KIND_END  = 1'b1;

  localparam logic [7:0] CH_QUOTE  = 8'h22;
  localparam logic [7:0] CH_BSLASH = 8'h5C;
  localparam logic [7:0] CH_BS     = 8'h08;
  localparam logic [7:0] CH_FF     = 8'h0C;
  localparam logic [7:0] CH_LF     = 8'h0A;
  localparam logic [7:0] CH_CR     = 8'h0D;
  localparam logic [7:0] CH_TAB    = 8'h09;
  localparam logic [7:0] CH_LC_B   = 8'h62;
  localparam logic [7:0] CH_LC_F   = 8'h66;
  localparam logic [7:0] CH_LC_N   = 8'h6E;
  localparam logic [7:0] CH_LC_R   = 8'h72;
  localparam logic [7:0] CH_LC_T   = 8'h74;
  localparam logic [7:0] CH_LC_U   = 8'h75;
  localparam logic [7:0] CH_ZERO   = 8'h30;
  localparam logic [7:0] CH_LC_D   = 8'h64;

  localparam logic [7:0] CTRL_LIMIT  = 8'h20;
  localparam logic [7:0] ASCII_LIMIT = 8'h80;

  localparam int          TAIL_MAX = 6;
  localparam int          HELD_MAX = 3;
  localparam int          QDEPTH   = 2;
  localparam int          QPTR_W   = (QDEPTH > 1) ? $clog2(QDEPTH) : 1;
  localparam int          QCNT_W   = $clog2(QDEPTH + 1);
  localparam logic [2:0]  REPL_LEN = 3'd6;

  typedef struct packed {
    logic       kind;
    logic [7:0] text_byte;
  } in_beat_t;

  typedef struct packed {
    logic [7:0] out_byte;
    logic       last_of_run;
    logic       string_closed;
  } out_beat_t;

  // Work for one accepted item: an optional opening quote, a number of
  // replacement sequences, and a tail of up to six literal bytes.
  typedef struct packed {
    logic                          open_quote;
    logic [1:0]                    bad_count;
    logic [TAIL_MAX-1:0][7:0]      tail;
    logic [2:0]                    tail_len;
    logic                          tail_closed;
  } plan_t;

  function automatic logic [7:0] hex_digit(input logic [3:0] nib);
    logic [7:0] r;
    if (nib < 4'd10) begin
      r = 8'h30 + {4'd0, nib};
    end else begin
      r = 8'h57 + {4'd0, nib};
    end
    return r;
  endfunction

  // Bytes of the six-character replacement escape, backslash u f f f d.
  function automatic logic [7:0] repl_char(input logic [2:0] idx);
    logic [7:0] r;
    case (idx)
      3'd0:    r = CH_BSLASH;
      3'd1:    r = CH_LC_U;
      3'd2:    r = CH_LC_F;
      3'd3:    r = CH_LC_F;
      3'd4:    r = CH_LC_F;
      3'd5:    r = CH_LC_D;
      default: r = CH_LC_D;
    endcase
    return r;
  endfunction

  function automatic logic follow_ok(input logic [7:0] lead, input logic [1:0] pos,
                                     input logic [7:0] b);
    logic r;
    r = (b[7:6] == 2'b10);
    if (pos == 2'd1) begin
      if (lead == 8'hE0) begin
        r = b inside {[8'hA0:8'hBF]};
      end else if (lead == 8'hED) begin
        r = b inside {[8'h80:8'h9F]};
      end else if (lead == 8'hF0) begin
        r = b inside {[8'h90:8'hBF]};
      end else if (lead == 8'hF4) begin
        r = b inside {[8'h80:8'h8F]};
      end
    end
    return r;
  endfunction

  function automatic logic [2:0] seq_length(input logic [7:0] lead);
    logic [2:0] r;
    if (lead <= 8'hDF) begin
      r = 3'd2;
    end else if (lead <= 8'hEF) begin
      r = 3'd3;
    end else begin
      r = 3'd4;
    end
    return r;
  endfunction

endpackage

/* design/json_string_escape_utf8_check.sv */
// ----------------------------------------------------------------------------
// json_string_escape_utf8_check
// JSON string quoting and escaping with UTF-8 well-formedness checking.
//
// The input channel takes one beat per string byte, or an end-of-string
// beat, and the output channel gives the quoted, escaped string one byte
// per beat. The last beat caused by an input beat carries last_of_run, and
// the closing quote carries string_closed. An input beat that only holds a
// byte of an incomplete UTF-8 sequence produces no output beats but for the
// opening quote of a string. A front stage classifies each input beat in the
// cycle it is accepted and writes a plan into a two-entry queue; a back
// stage expands the plan, one output byte per cycle unless the receiver
// stalls, into an output register. The first output byte of a beat is
// registered after its plan is written into the queue. A beat that yields
// one byte sustains one beat per cycle unless the receiver stalls; one that
// yields more bytes, up to 24, holds the back stage until its last byte is
// out; the input stalls once the queue is full. When the receiver stalls,
// the output register holds its beat and the queue fills. Reset empties
// the queue and output register and forgets any open string or held bytes.
// ----------------------------------------------------------------------------
module json_string_escape_utf8_check
  import jsesc_pkg::*;
(
  input  logic      clk_i,
  input  logic      rst_ni,
  input  logic      in_valid_i,
  output logic      in_stall_o,
  input  in_beat_t  in_data_i,
  output logic      out_valid_o,
  input  logic      out_stall_i,
  output out_beat_t out_data_o
);

  logic  accept;
  logic  push, pop, full, empty;
  plan_t plan, head;

  assign in_stall_o = full;
  assign accept     = in_valid_i && !full;

  jsesc_front u_front (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .accept_i (accept),
    .beat_i   (in_data_i),
    .push_o   (push),
    .plan_o   (plan)
  );

  jsesc_queue u_queue (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .push_i  (push),
    .plan_i  (plan),
    .pop_i   (pop),
    .full_o  (full),
    .empty_o (empty),
    .head_o  (head)
  );

  jsesc_back u_back (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .empty_i     (empty),
    .head_i      (head),
    .pop_o       (pop),
    .out_valid_o (out_valid_o),
    .out_stall_i (out_stall_i),
    .out_data_o  (out_data_o)
  );

endmodule

/* design/jsesc_front.sv */
// ----------------------------------------------------------------------------
// jsesc_front
// Accepts input beats, tracks the open quote and held UTF-8 bytes, and
// turns each beat with output into a plan of output bytes for the back end.
// ----------------------------------------------------------------------------
module jsesc_front
  import jsesc_pkg::*;
(
  input  logic     clk_i,
  input  logic     rst_ni,
  input  logic     accept_i,
  input  in_beat_t beat_i,
  output logic     push_o,
  output plan_t    plan_o
);

  logic                     quote_opened_q, quote_opened_d;
  logic [1:0]               held_count_q, held_count_d;
  logic [2:0]               seq_len_q, seq_len_d;
  logic [HELD_MAX-1:0][7:0] held_q, held_d;
  logic                     fresh;
  logic [7:0]               b;
  plan_t                    plan;

  assign b = beat_i.text_byte;

  always_comb begin
    plan             = '0;
    plan.open_quote  = !quote_opened_q;
    quote_opened_d   = quote_opened_q;
    held_count_d     = held_count_q;
    seq_len_d        = seq_len_q;
    held_d           = held_q;
    fresh            = 1'b0;
    if (accept_i) begin
      quote_opened_d = 1'b1;
      if (beat_i.kind == KIND_END) begin
        plan.bad_count   = held_count_q;
        plan.tail[0]     = CH_QUOTE;
        plan.tail_len    = 3'd1;
        plan.tail_closed = 1'b1;
        held_count_d     = 2'd0;
        seq_len_d        = 3'd0;
        quote_opened_d   = 1'b0;
      end else if (held_count_q == 2'd0) begin
        fresh = 1'b1;
      end else if (!follow_ok(held_q[0], held_count_q, b)) begin
        plan.bad_count = held_count_q;
        held_count_d   = 2'd0;
        seq_len_d      = 3'd0;
        fresh          = 1'b1;
      end else if (({1'b0, held_count_q} + 3'd1) >= seq_len_q) begin
        for (int i = 0; i < HELD_MAX; i++) begin
          if (2'(i) < held_count_q) begin
            plan.tail[i] = held_q[i];
          end
        end
        plan.tail[{1'b0, held_count_q}] = b;
        plan.tail_len                   = {1'b0, held_count_q} + 3'd1;
        held_count_d                    = 2'd0;
        seq_len_d                       = 3'd0;
      end else begin
        held_d[held_count_q] = b;
        held_count_d         = held_count_q + 2'd1;
      end

      if (fresh) begin
        case (b)
          CH_QUOTE: begin
            plan.tail[0] = CH_BSLASH; plan.tail[1] = CH_QUOTE;  plan.tail_len = 3'd2;
          end
          CH_BSLASH: begin
            plan.tail[0] = CH_BSLASH; plan.tail[1] = CH_BSLASH; plan.tail_len = 3'd2;
          end
          CH_BS: begin
            plan.tail[0] = CH_BSLASH; plan.tail[1] = CH_LC_B;   plan.tail_len = 3'd2;
          end
          CH_FF: begin
            plan.tail[0] = CH_BSLASH; plan.tail[1] = CH_LC_F;   plan.tail_len = 3'd2;
          end
          CH_LF: begin
            plan.tail[0] = CH_BSLASH; plan.tail[1] = CH_LC_N;   plan.tail_len = 3'd2;
          end
          CH_CR: begin
            plan.tail[0] = CH_BSLASH; plan.tail[1] = CH_LC_R;   plan.tail_len = 3'd2;
          end
          CH_TAB: begin
            plan.tail[0] = CH_BSLASH; plan.tail[1] = CH_LC_T;   plan.tail_len = 3'd2;
          end
          default: begin
            if (b < CTRL_LIMIT) begin
              plan.tail[0]  = CH_BSLASH;
              plan.tail[1]  = CH_LC_U;
              plan.tail[2]  = CH_ZERO;
              plan.tail[3]  = CH_ZERO;
              plan.tail[4]  = hex_digit(b[7:4]);
              plan.tail[5]  = hex_digit(b[3:0]);
              plan.tail_len = 3'd6;
            end else if (b < ASCII_LIMIT) begin
              plan.tail[0]  = b;
              plan.tail_len = 3'd1;
            end else if (b inside {[8'hC2:8'hF4]}) begin
              held_d[0]    = b;
              held_count_d = 2'd1;
              seq_len_d    = seq_length(b);
            end else begin
              for (int i = 0; i < TAIL_MAX; i++) begin
                plan.tail[i] = repl_char(3'(i));
              end
              plan.tail_len = REPL_LEN;
            end
          end
        endcase
      end
    end
  end

  assign plan_o = plan;
  assign push_o = accept_i &&
                  (plan.open_quote || (plan.bad_count != 2'd0) || (plan.tail_len != 3'd0));

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      quote_opened_q <= 1'b0;
      held_count_q   <= 2'd0;
      seq_len_q      <= 3'd0;
    end else begin
      quote_opened_q <= quote_opened_d;
      held_count_q   <= held_count_d;
      seq_len_q      <= seq_len_d;
    end
  end

  always_ff @(posedge clk_i) begin
    held_q <= held_d;
  end

  a_held_below_len: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (held_count_q != 2'd0) |-> ({1'b0, held_count_q} < seq_len_q))
    else $error("held byte count reached the sequence length");

  a_held_needs_open: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (held_count_q != 2'd0) |-> quote_opened_q)
    else $error("bytes held outside an open string");

  a_end_clears: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (accept_i && beat_i.kind == KIND_END) |=> (held_count_q == 2'd0) && !quote_opened_q)
    else $error("end of string left state behind");

endmodule

/* design/jsesc_queue.sv */
// ----------------------------------------------------------------------------
// jsesc_queue
// Two-entry queue of plans between the front and the back end.
// ----------------------------------------------------------------------------
module jsesc_queue
  import jsesc_pkg::*;
(
  input  logic  clk_i,
  input  logic  rst_ni,
  input  logic  push_i,
  input  plan_t plan_i,
  input  logic  pop_i,
  output logic  full_o,
  output logic  empty_o,
  output plan_t head_o
);

  plan_t             mem_q [QDEPTH];
  logic [QPTR_W-1:0] wr_ptr_q, rd_ptr_q;
  logic [QCNT_W-1:0] count_q;

  assign full_o  = (count_q == QCNT_W'(QDEPTH));
  assign empty_o = (count_q == '0);
  assign head_o  = mem_q[rd_ptr_q];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      count_q  <= '0;
    end else begin
      if (push_i) begin
        wr_ptr_q <= (wr_ptr_q == QPTR_W'(QDEPTH - 1)) ? '0 : wr_ptr_q + 1'b1;
      end
      if (pop_i) begin
        rd_ptr_q <= (rd_ptr_q == QPTR_W'(QDEPTH - 1)) ? '0 : rd_ptr_q + 1'b1;
      end
      if (push_i && !pop_i) begin
        count_q <= count_q + 1'b1;
      end else if (pop_i && !push_i) begin
        count_q <= count_q - 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (push_i) begin
      mem_q[wr_ptr_q] <= plan_i;
    end
  end

  a_no_overflow: assert property (@(posedge clk_i) disable iff (!rst_ni)
    push_i |-> !full_o)
    else $error("push into a full queue");

  a_no_underflow: assert property (@(posedge clk_i) disable iff (!rst_ni)
    pop_i |-> !empty_o)
    else $error("pop from an empty queue");

  a_count_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    count_q <= QCNT_W'(QDEPTH))
    else $error("queue count out of range");

endmodule

/* design/jsesc_back.sv */
// ----------------------------------------------------------------------------
// jsesc_back
// Expands the plan at the head of the queue into output beats, one byte
// per cycle unless the receiver stalls, through an output register.
// ----------------------------------------------------------------------------
module jsesc_back
  import jsesc_pkg::*;
(
  input  logic      clk_i,
  input  logic      rst_ni,
  input  logic      empty_i,
  input  plan_t     head_i,
  output logic      pop_o,
  output logic      out_valid_o,
  input  logic      out_stall_i,
  output out_beat_t out_data_o
);

  localparam logic [1:0] PH_OPEN = 2'd0;
  localparam logic [1:0] PH_BAD  = 2'd1;
  localparam logic [1:0] PH_TAIL = 2'd2;

  logic [1:0] phase_q, phase_d;
  logic [1:0] rep_q, rep_d;
  logic [2:0] idx_q, idx_d;
  logic [2:0] rep_inc, idx_inc;
  logic       in_open, in_bad;
  logic       load, take, last;
  logic       out_valid_q;
  out_beat_t  out_q, beat;

  assign load    = !out_valid_q || !out_stall_i;
  assign take    = load && !empty_i;
  assign rep_inc = {1'b0, rep_q} + 3'd1;
  assign idx_inc = idx_q + 3'd1;
  assign in_open = (phase_q == PH_OPEN) && head_i.open_quote;
  assign in_bad  = !in_open && (phase_q != PH_TAIL) && (rep_q < head_i.bad_count);

  always_comb begin
    beat    = '0;
    last    = 1'b0;
    phase_d = phase_q;
    rep_d   = rep_q;
    idx_d   = idx_q;
    if (in_open) begin
      beat.out_byte = CH_QUOTE;
      last          = (head_i.bad_count == 2'd0) && (head_i.tail_len == 3'd0);
      phase_d       = PH_BAD;
      rep_d         = 2'd0;
      idx_d         = 3'd0;
    end else if (in_bad) begin
      beat.out_byte = repl_char(idx_q);
      phase_d       = PH_BAD;
      if (idx_q == REPL_LEN - 3'd1) begin
        last  = (rep_inc == {1'b0, head_i.bad_count}) && (head_i.tail_len == 3'd0);
        rep_d = rep_inc[1:0];
        idx_d = 3'd0;
      end else begin
        idx_d = idx_inc;
      end
    end else begin
      beat.out_byte      = head_i.tail[idx_q];
      beat.string_closed = head_i.tail_closed;
      last               = (idx_inc == head_i.tail_len);
      phase_d            = PH_TAIL;
      idx_d              = idx_inc;
    end
    beat.last_of_run = last;
    if (last) begin
      phase_d = PH_OPEN;
      rep_d   = 2'd0;
      idx_d   = 3'd0;
    end
  end

  assign pop_o = take && last;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q     <= PH_OPEN;
      rep_q       <= 2'd0;
      idx_q       <= 3'd0;
      out_valid_q <= 1'b0;
    end else begin
      if (take) begin
        phase_q <= phase_d;
        rep_q   <= rep_d;
        idx_q   <= idx_d;
      end
      if (load) begin
        out_valid_q <= !empty_i;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (take) begin
      out_q <= beat;
    end
  end

  assign out_valid_o = out_valid_q;
  assign out_data_o  = out_q;

  a_tail_in_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (!empty_i && !in_open && !in_bad) |-> (idx_q < head_i.tail_len))
    else $error("tail index beyond the planned bytes");

  a_closed_is_last: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_q && out_q.string_closed) |-> out_q.last_of_run)
    else $error("closing quote not at the end of its run");

  a_idle_at_start: assert property (@(posedge clk_i) disable iff (!rst_ni)
    pop_o |=> (phase_q == PH_OPEN) && (rep_q == 2'd0) && (idx_q == 3'd0))
    else $error("sequencer not rewound after a plan");

endmodule
